// ===== hw/rtl/stereo_ppm_level_meter_top_macros.svh =====
// ----------------------------------------------------------------------------
// Stereo PPM level meter assertion macros
// Shared concurrent assertion wrappers for the checker.
// ----------------------------------------------------------------------------
`ifndef STEREO_PPM_LEVEL_METER_TOP_MACROS_SVH
`define STEREO_PPM_LEVEL_METER_TOP_MACROS_SVH

// checked only outside reset
`define SPPM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked during reset as well
`define SPPM_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hw/rtl/sppm_pkg.sv =====
// ----------------------------------------------------------------------------
// sppm_pkg
// Types and fixed constants of the stereo PPM level meter.
// ----------------------------------------------------------------------------
package sppm_pkg;
    localparam int SAMPLE_W = 16;
    localparam int READING_W = 16;
    localparam int ANGLE_W = 16;

    localparam logic signed [READING_W-1:0] READING_RESET = -16'sd15360;
    localparam logic [ANGLE_W-1:0] ANGLE_MAX = 16'd46080;
    localparam logic [31:0] DB_PER_OCT_Q16 = 32'd394566;
    localparam logic signed [20:0] ANGLE_BASE = 21'sd149760;
    // ceil(2^24 / 11), exact floor divide for dividends below 2^21
    localparam logic [31:0] ANGLE_RECIP = 32'd1525202;

    localparam logic [2:0] REG_DECAY = 3'd0;
    localparam logic [2:0] REG_WEIGHT = 3'd1;
    localparam logic [2:0] REG_FLOOR = 3'd2;
    localparam logic [2:0] REG_OFFSET = 3'd3;
    localparam logic [2:0] REG_CLIP = 3'd4;

    typedef logic [SAMPLE_W-1:0] mag_t;
endpackage

// ===== hw/rtl/sppm_div.sv =====
// ----------------------------------------------------------------------------
// sppm_div
// Restoring shift-subtract divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sppm_div #(
    parameter int DW = 29,
    parameter int VW = 13
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          busy,
    output logic [DW-1:0] quot
);
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] q_reg, q_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW-1:0] dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [VW:0]   rem_sh;
    logic [VW:0]   rem_sub;

    always_comb begin
        rem_sh = {rem_reg, q_reg[DW-1]};
        rem_sub = rem_sh - {1'b0, dvs_reg};
        q_next = q_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            q_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = CW'(DW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_sh >= {1'b0, dvs_reg}) begin
                rem_next = rem_sub[VW-1:0];
                q_next = {q_reg[DW-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[VW-1:0];
                q_next = {q_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy = busy_reg;
    assign quot = q_reg;
endmodule

// ===== hw/rtl/sppm_accum.sv =====
// ----------------------------------------------------------------------------
// sppm_accum
// Window accumulator: absolute sums, sample count and clip detect.
// ----------------------------------------------------------------------------
module sppm_accum #(
    parameter int MAX_WINDOW = 4096,
    parameter int CNT_W = 13,
    parameter int SUM_W = 29
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 add,
    input  logic                                 clear,
    input  logic signed [sppm_pkg::SAMPLE_W-1:0] left,
    input  logic signed [sppm_pkg::SAMPLE_W-1:0] right,
    input  logic [15:0]                          threshold,
    output logic [SUM_W-1:0]                     sum_left,
    output logic [SUM_W-1:0]                     sum_right,
    output logic [CNT_W-1:0]                     count,
    output logic                                 clip
);
    logic [SUM_W-1:0]  sum_l_reg, sum_l_next;
    logic [SUM_W-1:0]  sum_r_reg, sum_r_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              clip_reg, clip_next;
    sppm_pkg::mag_t    abs_l, abs_r;

    always_comb begin
        abs_l = left[15] ? sppm_pkg::mag_t'(-left) : sppm_pkg::mag_t'(left);
        abs_r = right[15] ? sppm_pkg::mag_t'(-right) : sppm_pkg::mag_t'(right);
        sum_l_next = sum_l_reg;
        sum_r_next = sum_r_reg;
        cnt_next = cnt_reg;
        clip_next = clip_reg;
        if (clear) begin
            sum_l_next = '0;
            sum_r_next = '0;
            cnt_next = '0;
            clip_next = 1'b0;
        end else if (add && (cnt_reg < CNT_W'(MAX_WINDOW))) begin
            sum_l_next = sum_l_reg + SUM_W'(abs_l);
            sum_r_next = sum_r_reg + SUM_W'(abs_r);
            cnt_next = cnt_reg + 1'b1;
            if ((abs_l >= threshold) || (abs_r >= threshold)) begin
                clip_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_l_reg <= '0;
            sum_r_reg <= '0;
            cnt_reg <= '0;
            clip_reg <= 1'b0;
        end else begin
            sum_l_reg <= sum_l_next;
            sum_r_reg <= sum_r_next;
            cnt_reg <= cnt_next;
            clip_reg <= clip_next;
        end
    end

    assign sum_left = sum_l_reg;
    assign sum_right = sum_r_reg;
    assign count = cnt_reg;
    assign clip = clip_reg;
endmodule

// ===== hw/rtl/stereo_ppm_level_meter_top.sv =====
// ----------------------------------------------------------------------------
// stereo_ppm_level_meter_top
// Stereo peak programme meter with leaky dB readings and needle angles.
// ----------------------------------------------------------------------------
// A word that does not close a window is taken while the meter is idle. A
// word with tlast starts the window update, and s_tready stays low until
// the result word is loaded: per channel a mean divide (SUM_W =
// clog2(MAX_WINDOW+1)+16), a normalize, 16 squaring steps for log2, the
// dB, meter and angle math and a channel step; a zero mean skips the
// normalize and log2. The divider serves the mean; one 32x32 multiplier
// serves squaring, dB, meter and the angle divide by 11 (reciprocal
// multiply).
module stereo_ppm_level_meter_top #(
    parameter int MAX_WINDOW = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // left_sample, right_sample
    input  logic        s_tlast,   // last_of_window
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // meter_left_db, meter_right_db, angle_left, angle_right
    output logic [1:0]  m_tuser,   // clip_flag, over_flag
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = CNT_W + 16;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIVS  = 4'd1;
    localparam logic [3:0] S_WAITM = 4'd2;
    localparam logic [3:0] S_NORM  = 4'd3;
    localparam logic [3:0] S_SQ    = 4'd4;
    localparam logic [3:0] S_DB    = 4'd5;
    localparam logic [3:0] S_MET1  = 4'd6;
    localparam logic [3:0] S_MET2  = 4'd7;
    localparam logic [3:0] S_ANG   = 4'd8;
    localparam logic [3:0] S_NEXT  = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [15:0]        decay_reg, weight_reg, clip_thr_reg;
    logic signed [15:0] floor_reg;
    logic [14:0]        offset_reg;

    logic [3:0]         state_reg, state_next;
    logic               ch_reg, ch_next;
    logic [30:0]        m_reg, m_next;
    logic [3:0]         e_reg, e_next;
    logic [15:0]        frac_reg, frac_next;
    logic [3:0]         sq_cnt_reg, sq_cnt_next;
    logic signed [16:0] level_reg, level_next;
    logic signed [33:0] acc_reg, acc_next;
    logic signed [15:0] rd_reg [2];
    logic signed [15:0] rd_next [2];
    logic [15:0]        ang_reg [2];
    logic [15:0]        ang_next [2];
    logic               clip_hold_reg, clip_hold_next;
    logic               out_valid_reg, out_valid_next;
    logic [63:0]        out_data_reg, out_data_next;
    logic [1:0]         out_user_reg, out_user_next;

    logic               acc_add, acc_clear;
    logic [SUM_W-1:0]   sum_l, sum_r;
    logic [CNT_W-1:0]   win_cnt;
    logic               win_clip;

    logic               div_start, div_busy;
    logic [SUM_W-1:0]   div_dvd, div_q;
    logic [CNT_W-1:0]   div_dvs;

    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;

    logic [31:0]        sq;
    logic [14:0]        db;
    logic signed [16:0] diff;
    logic signed [33:0] msum;
    logic signed [17:0] mq;
    logic signed [20:0] r_ext, num;
    logic [16:0]        aq;
    logic signed [15:0] cur_rd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decay_reg <= 16'd64218;
            weight_reg <= 16'd983;
            floor_reg <= -16'sd12800;
            offset_reg <= 15'd20557;
            clip_thr_reg <= 16'd32766;
        end else if (cfg_valid) begin
            case (cfg_index)
                sppm_pkg::REG_DECAY:  decay_reg <= cfg_data;
                sppm_pkg::REG_WEIGHT: weight_reg <= cfg_data;
                sppm_pkg::REG_FLOOR:  floor_reg <= cfg_data;
                sppm_pkg::REG_OFFSET: offset_reg <= cfg_data[14:0];
                sppm_pkg::REG_CLIP:   clip_thr_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign acc_add = s_tvalid && s_tready;
    assign acc_clear = (state_reg == S_NEXT) && ch_reg;

    sppm_accum #(
        .MAX_WINDOW(MAX_WINDOW),
        .CNT_W(CNT_W),
        .SUM_W(SUM_W)
    ) u_accum (
        .aclk(aclk),
        .aresetn(aresetn),
        .add(acc_add),
        .clear(acc_clear),
        .left(s_tdata[15:0]),
        .right(s_tdata[31:16]),
        .threshold(clip_thr_reg),
        .sum_left(sum_l),
        .sum_right(sum_r),
        .count(win_cnt),
        .clip(win_clip)
    );

    sppm_div #(
        .DW(SUM_W),
        .VW(CNT_W)
    ) u_div (
        .aclk(aclk),
        .aresetn(aresetn),
        .start(div_start),
        .dividend(div_dvd),
        .divisor(div_dvs),
        .busy(div_busy),
        .quot(div_q)
    );

    assign cur_rd = rd_reg[ch_reg];

    always_comb begin
        r_ext = 21'(cur_rd);
        num = sppm_pkg::ANGLE_BASE - (r_ext <<< 4) - (r_ext <<< 1);
        case (state_reg)
            S_SQ: begin
                mul_a = {1'b0, m_reg};
                mul_b = {1'b0, m_reg};
            end
            S_DB: begin
                mul_a = {12'd0, e_reg, frac_reg};
                mul_b = sppm_pkg::DB_PER_OCT_Q16;
            end
            S_MET1: begin
                mul_a = {16'd0, decay_reg};
                mul_b = 32'(cur_rd);
            end
            S_MET2: begin
                mul_a = {16'd0, weight_reg};
                mul_b = 32'(level_reg);
            end
            S_ANG: begin
                mul_a = 32'(num + 21'sd5);
                mul_b = sppm_pkg::ANGLE_RECIP;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    always_comb begin
        sq = mul_p[61:30];
        db = mul_p[38:24];
        diff = $signed({2'b00, db}) - $signed({2'b00, offset_reg});
        msum = acc_reg + mul_p[33:0];
        mq = msum[33:16];
        aq = mul_p[40:24];

        state_next = state_reg;
        ch_next = ch_reg;
        m_next = m_reg;
        e_next = e_reg;
        frac_next = frac_reg;
        sq_cnt_next = sq_cnt_reg;
        level_next = level_reg;
        acc_next = acc_reg;
        rd_next = rd_reg;
        ang_next = ang_reg;
        clip_hold_next = clip_hold_reg;
        out_data_next = out_data_reg;
        out_user_next = out_user_reg;
        out_valid_next = out_valid_reg && !m_tready;
        div_start = 1'b0;
        div_dvd = ch_reg ? sum_r : sum_l;
        div_dvs = win_cnt;

        case (state_reg)
            S_IDLE: begin
                if (acc_add && s_tlast) begin
                    ch_next = 1'b0;
                    state_next = S_DIVS;
                end
            end
            S_DIVS: begin
                div_start = 1'b1;
                state_next = S_WAITM;
            end
            S_WAITM: begin
                if (!div_busy) begin
                    if (div_q[15:0] == 16'd0) begin
                        level_next = 17'(floor_reg);
                        state_next = S_MET1;
                    end else begin
                        m_next = {div_q[15:0], 15'd0};
                        e_next = 4'd15;
                        state_next = S_NORM;
                    end
                end
            end
            S_NORM: begin
                if (m_reg[30]) begin
                    frac_next = '0;
                    sq_cnt_next = '0;
                    state_next = S_SQ;
                end else begin
                    m_next = {m_reg[29:0], 1'b0};
                    e_next = e_reg - 1'b1;
                end
            end
            S_SQ: begin
                if (sq[31]) begin
                    frac_next = {frac_reg[14:0], 1'b1};
                    m_next = sq[31:1];
                end else begin
                    frac_next = {frac_reg[14:0], 1'b0};
                    m_next = sq[30:0];
                end
                sq_cnt_next = sq_cnt_reg + 1'b1;
                if (sq_cnt_reg == 4'd15) begin
                    state_next = S_DB;
                end
            end
            S_DB: begin
                level_next = (diff < 17'(floor_reg)) ? 17'(floor_reg) : diff;
                state_next = S_MET1;
            end
            S_MET1: begin
                acc_next = mul_p[33:0];
                state_next = S_MET2;
            end
            S_MET2: begin
                if (mq > 18'sd32767) begin
                    rd_next[ch_reg] = 16'sh7FFF;
                end else if (mq < -18'sd32768) begin
                    rd_next[ch_reg] = 16'sh8000;
                end else begin
                    rd_next[ch_reg] = mq[15:0];
                end
                state_next = S_ANG;
            end
            S_ANG: begin
                if (num < 0) begin
                    ang_next[ch_reg] = '0;
                end else begin
                    ang_next[ch_reg] = (aq > 17'(sppm_pkg::ANGLE_MAX)) ?
                        sppm_pkg::ANGLE_MAX : aq[15:0];
                end
                state_next = S_NEXT;
            end
            S_NEXT: begin
                if (!ch_reg) begin
                    ch_next = 1'b1;
                    state_next = S_DIVS;
                end else begin
                    clip_hold_next = win_clip;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    out_data_next = {ang_reg[1], ang_reg[0], rd_reg[1], rd_reg[0]};
                    out_user_next = {clip_hold_reg || !rd_reg[0][15] || !rd_reg[1][15],
                                     clip_hold_reg};
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ch_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            rd_reg[0] <= sppm_pkg::READING_RESET;
            rd_reg[1] <= sppm_pkg::READING_RESET;
        end else begin
            state_reg <= state_next;
            ch_reg <= ch_next;
            out_valid_reg <= out_valid_next;
            rd_reg <= rd_next;
        end
        m_reg <= m_next;
        e_reg <= e_next;
        frac_reg <= frac_next;
        sq_cnt_reg <= sq_cnt_next;
        level_reg <= level_next;
        acc_reg <= acc_next;
        ang_reg <= ang_next;
        clip_hold_reg <= clip_hold_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;
    assign m_tuser = out_user_reg;
endmodule

// ===== hw/rtl/sppm_checker.sv =====
// ----------------------------------------------------------------------------
// sppm_checker
// Port-level checks of the stereo PPM level meter result channel.
// ----------------------------------------------------------------------------
`include "stereo_ppm_level_meter_top_macros.svh"

module sppm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser
);
    `SPPM_ASSERT_RST(a_no_word_after_reset, !aresetn |=> !m_tvalid, "result word after reset")
    `SPPM_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "word dropped")
    `SPPM_ASSERT(a_angle_l, m_tvalid |-> m_tdata[47:32] <= 16'd46080, "left angle range")
    `SPPM_ASSERT(a_angle_r, m_tvalid |-> m_tdata[63:48] <= 16'd46080, "right angle range")
    `SPPM_ASSERT(a_over, m_tvalid |-> m_tuser[1] == (m_tuser[0] || !m_tdata[15] || !m_tdata[31]), "over flag")
endmodule

bind stereo_ppm_level_meter_top sppm_checker u_sppm_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
);
